@@ hw/rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared types and status codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOT_FND = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	localparam logic [0:0] REG_HEAP_BASE  = 1'b0;
	localparam logic [0:0] REG_HEAP_BYTES = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_WAIT,
		S_CHECK,
		S_SHIFT_RD,
		S_SHIFT_WAIT,
		S_SHIFT_WR,
		S_PUT,
		S_DONE
	} state_t;

endpackage

@@ hw/rtl/ffba_if.sv @@
// ----------------------------------------------------------------------------
// Request and response channels
// Valid/ready channels carrying the allocator request and response payloads.
// ----------------------------------------------------------------------------
interface ffba_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] request_bytes;
	logic [31:0] free_address;
	modport source (output valid, mode, request_bytes, free_address, input ready);
	modport sink (input valid, mode, request_bytes, free_address, output ready);
endinterface

interface ffba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_address;
	logic [1:0]  status;
	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

@@ hw/rtl/ffba_table.sv @@
// ----------------------------------------------------------------------------
// Block table memory
// One write port and one registered read port holding offset and size.
// ----------------------------------------------------------------------------
module ffba_table #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/first_fit_block_allocator.sv @@
// An allocate walks blocks, then shifts entries up; a free compares blocks,
// then shifts entries down. One request is handled at a time: a new one is
// taken only while idle with no response pending, and each step waits on
// the registered table read.
// Reset: registers go to heap_base 0 and heap_bytes 65536, one live block
// (the head, implied and never stored); no clearing pass over the table is needed.
// ----------------------------------------------------------------------------
// First-fit block allocator
// Sequencer walking an address-ordered block table held in one memory.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = 64,
	parameter int TAG_BYTES  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);
	localparam int AW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [32:0] TAG = 33'(TAG_BYTES);

	ffba_pkg::state_t state_q, state_d;

	logic [31:0] base_q, bytes_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;      // walk index / shift pointer
	logic [CW-1:0] pos_q;      // insert or remove position
	logic          mode_q;
	logic [31:0] req_q, addr_q;
	logic [32:0] prev_end_q;   // end of the lower block during an allocate walk
	logic [31:0] new_off_q;
	logic [31:0] gaddr_q;
	logic [1:0]  status_q;
	logic        rsp_valid_q;
	logic [63:0] hold_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata, rdata;

	// Entry 0 is the head block and is never stored: index k maps to k-1.
	ffba_table #(.AW(AW)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [31:0] rd_off, rd_size;
	assign rd_off  = rdata[63:32];
	assign rd_size = rdata[31:0];

	// Separate adders: data address of the entry just read, its end, and the gap before it.
	logic [32:0] need, rd_end, gap;
	logic [33:0] place_end;
	logic [31:0] rd_daddr;
	assign need      = {1'b0, req_q} + TAG;
	assign rd_end    = {1'b0, rd_off} + TAG + {1'b0, rd_size};
	assign gap       = {1'b0, rd_off} - prev_end_q;
	assign rd_daddr  = base_q + rd_off + TAG[31:0];
	assign place_end = {2'b0, prev_end_q[31:0]} + {1'b0, need};

	logic [CW-1:0] idx_m1;
	assign idx_m1 = idx_q - CW'(1);

	assign req.ready       = (state_q == ffba_pkg::S_IDLE) && !rsp_valid_q;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.granted_address = gaddr_q;
	assign rsp.status      = status_q;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = idx_m1[AW-1:0];
		wdata   = hold_q;
		raddr   = idx_m1[AW-1:0];
		unique case (state_q)
			ffba_pkg::S_IDLE:       state_d = state_q;
			ffba_pkg::S_RD:         state_d = ffba_pkg::S_WAIT;
			ffba_pkg::S_WAIT:       state_d = ffba_pkg::S_CHECK;
			ffba_pkg::S_CHECK:      state_d = state_q;
			ffba_pkg::S_SHIFT_RD: begin
				state_d = ffba_pkg::S_SHIFT_WAIT;
				if (mode_q == ffba_pkg::MODE_ALLOC) begin
					raddr = AW'(idx_q - CW'(2));   // fetch entry idx-1
				end
			end
			ffba_pkg::S_SHIFT_WAIT: begin
				state_d = ffba_pkg::S_SHIFT_WR;
				if (mode_q == ffba_pkg::MODE_ALLOC) begin
					raddr = AW'(idx_q - CW'(2));
				end
			end
			ffba_pkg::S_SHIFT_WR: begin
				we = 1'b1;
				if (mode_q == ffba_pkg::MODE_ALLOC) begin
					waddr = idx_m1[AW-1:0];         // entry idx-1 moves to idx
				end else begin
					waddr = AW'(idx_q - CW'(2));    // entry idx moves to idx-1
				end
				wdata = rdata;
			end
			ffba_pkg::S_PUT: begin
				we    = 1'b1;
				waddr = AW'(pos_q - CW'(1));
				wdata = {new_off_q, req_q};
			end
			ffba_pkg::S_DONE: state_d = state_q;
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::S_IDLE;
			base_q      <= '0;
			bytes_q     <= 32'd65536;
			count_q     <= CW'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ffba_pkg::REG_HEAP_BASE) base_q <= cfg_wdata;
				else bytes_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ffba_pkg::S_IDLE: begin
					if (req.valid && req.ready) begin
						mode_q     <= req.mode;
						req_q      <= req.request_bytes;
						addr_q     <= req.free_address;
						gaddr_q    <= '0;
						status_q   <= ffba_pkg::ST_OK;
						prev_end_q <= TAG;   // head block: offset 0, size 0
						idx_q      <= CW'(1);
						if (req.mode == ffba_pkg::MODE_ALLOC
						    && count_q == CW'(MAX_BLOCKS)) begin
							status_q <= ffba_pkg::ST_FULL;
							state_q  <= ffba_pkg::S_DONE;
						end else if (count_q == CW'(1)) begin
							// nothing to walk
							if (req.mode == ffba_pkg::MODE_FREE) begin
								status_q <= ffba_pkg::ST_NOT_FND;
								state_q  <= ffba_pkg::S_DONE;
							end else begin
								state_q <= ffba_pkg::S_CHECK;
							end
						end else begin
							state_q <= ffba_pkg::S_RD;
						end
					end
				end
				ffba_pkg::S_RD, ffba_pkg::S_SHIFT_RD, ffba_pkg::S_SHIFT_WAIT:
					state_q <= state_d;
				ffba_pkg::S_WAIT: state_q <= state_d;
				ffba_pkg::S_CHECK: begin
					if (idx_q == count_q) begin
						// walk ran off the end
						if (mode_q == ffba_pkg::MODE_FREE) begin
							status_q <= ffba_pkg::ST_NOT_FND;
							state_q  <= ffba_pkg::S_DONE;
						end else if (place_end <= {2'b0, bytes_q}
						             && !prev_end_q[32]) begin
							new_off_q <= prev_end_q[31:0];
							gaddr_q   <= base_q + prev_end_q[31:0] + TAG[31:0];
							pos_q     <= count_q;
							count_q   <= count_q + CW'(1);
							state_q   <= ffba_pkg::S_PUT;
						end else if (place_end <= {2'b0, bytes_q}) begin
							status_q <= ffba_pkg::ST_NO_ROOM;
							state_q  <= ffba_pkg::S_DONE;
						end else begin
							status_q <= ffba_pkg::ST_NO_ROOM;
							state_q  <= ffba_pkg::S_DONE;
						end
					end else if (mode_q == ffba_pkg::MODE_ALLOC) begin
						if ({1'b0, rd_off} >= prev_end_q && gap >= need) begin
							new_off_q <= prev_end_q[31:0];
							gaddr_q   <= base_q + prev_end_q[31:0] + TAG[31:0];
							pos_q     <= idx_q;
							idx_q     <= count_q;       // shift from the top down
							count_q   <= count_q + CW'(1);
							state_q   <= ffba_pkg::S_SHIFT_RD;
						end else begin
							prev_end_q <= rd_end;
							idx_q      <= idx_q + CW'(1);
							state_q    <= (idx_q + CW'(1) == count_q)
							              ? ffba_pkg::S_CHECK : ffba_pkg::S_RD;
						end
					end else begin
						if (rd_daddr == addr_q) begin
							idx_q   <= idx_q + CW'(1);
							count_q <= count_q - CW'(1);
							pos_q   <= count_q;          // old count bounds the shift
							state_q <= (idx_q + CW'(1) == count_q)
							           ? ffba_pkg::S_DONE : ffba_pkg::S_SHIFT_RD;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= (idx_q + CW'(1) == count_q)
							           ? ffba_pkg::S_CHECK : ffba_pkg::S_RD;
						end
					end
				end
				ffba_pkg::S_SHIFT_WR: begin
					if (mode_q == ffba_pkg::MODE_ALLOC) begin
						// moved entry idx-1 to idx; continue down to pos
						idx_q   <= idx_m1;
						state_q <= (idx_m1 == pos_q) ? ffba_pkg::S_PUT
						                             : ffba_pkg::S_SHIFT_RD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == pos_q) ? ffba_pkg::S_DONE
						                                     : ffba_pkg::S_SHIFT_RD;
					end
				end
				ffba_pkg::S_PUT:  state_q <= ffba_pkg::S_DONE;
				ffba_pkg::S_DONE: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ffba_pkg::S_IDLE;
				end
				default: state_q <= ffba_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= rdata;
	end
endmodule
